// ===== rtl/core/gld_pkg.sv =====
`timescale 1ns / 1ps
package gld_pkg;

	localparam int TABLE_DEPTH_DEF   = 4096;
	localparam int MAX_CODE_BITS_DEF = 12;
	localparam int STACK_DEPTH       = 4096;
	localparam int STACK_AW          = 12;
	localparam int CODE_W            = 12;
	localparam int CNT_W             = 13;
	localparam int BUF_BITS          = 24;

	localparam logic [3:0] MIN_SIZE_RST    = 4'd8;
	localparam logic [8:0] COLOR_COUNT_RST = 9'd256;

	typedef enum logic {
		CFG_MIN_CODE_SIZE = 1'b0,
		CFG_COLOR_COUNT   = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_FIRST = 2'd1,
		ERR_SEQ   = 2'd2
	} err_t;

	typedef enum logic {
		FUNC_FEED = 1'b0,
		FUNC_PULL = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_WALK,
		ST_WALK_WAIT,
		ST_FIXUP,
		ST_POP,
		ST_POP_WAIT
	} state_t;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] color_index;
		logic       index_valid;
		logic       need_byte;
		logic       stream_done;
		logic [1:0] error_code;
	} out_item_t;

	typedef struct packed {
		logic     valid;
		in_item_t item;
	} queue_head_t;

endpackage

// ===== rtl/core/gld_ram.sv =====
`timescale 1ns / 1ps
module gld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/gld_front.sv =====
`timescale 1ns / 1ps
module gld_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  gld_pkg::in_item_t    in_item,
	output gld_pkg::queue_head_t head,
	input  logic                 pop
);

	gld_pkg::in_item_t entries_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              push;
	logic              do_pop;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign do_pop   = pop && (cnt_q != 2'd0);
	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !do_pop) |=> cnt_q == 2'd2)
		else $error("queue lost an item");
`endif

endmodule

// ===== rtl/core/gld_core.sv =====
`timescale 1ns / 1ps
module gld_core #(
	parameter int TABLE_DEPTH   = gld_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gld_pkg::queue_head_t head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output gld_pkg::out_item_t   out_item,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [8:0]           cfg_data
);

	localparam int TAW = $clog2(TABLE_DEPTH);
	localparam logic [gld_pkg::CNT_W-1:0] TD = (gld_pkg::CNT_W)'(TABLE_DEPTH);
	localparam logic [gld_pkg::CNT_W-1:0] SD = (gld_pkg::CNT_W)'(gld_pkg::STACK_DEPTH);
	localparam logic [3:0] MAXW = 4'(MAX_CODE_BITS);

	gld_pkg::state_t state_q, state_d;

	logic [3:0]  min_q;
	logic [8:0]  color_count_q;
	logic [3:0]  min_n;
	logic [3:0]  eff_min;
	logic [3:0]  eff_min_n;
	logic [8:0]  clr_val;
	logic [8:0]  clear_n;
	logic [11:0] first_entry;

	logic [gld_pkg::CNT_W-1:0] stack_cnt_q;
	logic [23:0] buf_q;
	logic [4:0]  bit_cnt_q;
	logic [3:0]  width_q;
	logic [gld_pkg::CNT_W-1:0] nf_q;
	logic [11:0] prev_q;
	logic        expect_first_q;
	logic        done_q;
	logic [1:0]  err_q;
	logic [11:0] walk_q;
	logic [gld_pkg::CNT_W-1:0] guard_q;
	logic        unknown_q;
	logic [11:0] code_q;
	logic [7:0]  first_q;
	logic        out_valid_q;
	gld_pkg::out_item_t out_q;

	logic        out_free;
	logic        take;
	logic [11:0] code;
	logic        walk_more;
	logic        nf_room;
	logic [gld_pkg::CNT_W-1:0] nf_inc;
	logic        grow;

	logic        push_en;
	logic [7:0]  push_data;
	logic        stack_we;
	logic [gld_pkg::STACK_AW-1:0] stack_waddr;
	logic [7:0]  stack_wdata;
	logic [gld_pkg::STACK_AW-1:0] stack_raddr;
	logic [7:0]  stack_rdata;
	logic        tab_we;
	logic [TAW-1:0] tab_raddr;
	logic [11:0] prefix_rdata;
	logic [7:0]  suffix_rdata;
	logic        emit;
	gld_pkg::out_item_t res;

	assign min_n = (cfg_we && cfg_index == gld_pkg::CFG_MIN_CODE_SIZE) ? cfg_data[3:0] : min_q;
	assign eff_min   = (min_q == 4'd0) ? 4'd1 : (min_q > 4'd8) ? 4'd8 : min_q;
	assign eff_min_n = (min_n == 4'd0) ? 4'd1 : (min_n > 4'd8) ? 4'd8 : min_n;
	assign clr_val     = 9'd1 << eff_min;
	assign clear_n     = 9'd1 << eff_min_n;
	assign first_entry = 12'(clr_val) + 12'd2;

	assign out_free = !out_valid_q || !out_stall;
	assign take     = (state_q == gld_pkg::ST_IDLE) && head.valid && out_free;
	assign pop      = take;
	assign code     = 12'(buf_q & ~(24'hFFFFFF << width_q));
	assign walk_more = (walk_q >= first_entry) && ({1'b0, walk_q} < TD) && (guard_q < TD);
	assign nf_room  = nf_q < TD;
	assign nf_inc   = nf_room ? nf_q + 13'd1 : nf_q;
	assign grow     = (nf_inc == (13'd1 << width_q)) && (width_q < MAXW);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gld_pkg::ST_IDLE: begin
				if (take && head.item.func == gld_pkg::FUNC_PULL) begin
					state_d = (stack_cnt_q != '0) ? gld_pkg::ST_POP_WAIT : gld_pkg::ST_DECODE;
				end
			end
			gld_pkg::ST_DECODE: begin
				if (done_q || err_q != gld_pkg::ERR_OK || bit_cnt_q < 5'(width_q)) begin
					state_d = gld_pkg::ST_IDLE;
				end else if (code == 12'(clr_val)) begin
					state_d = gld_pkg::ST_DECODE;
				end else if (code == 12'(clr_val) + 12'd1) begin
					state_d = gld_pkg::ST_IDLE;
				end else if (expect_first_q) begin
					state_d = (code >= 12'(color_count_q) || code >= 12'(clr_val)) ?
						gld_pkg::ST_IDLE : gld_pkg::ST_POP;
				end else if ({1'b0, code} < nf_q) begin
					state_d = gld_pkg::ST_WALK;
				end else if (nf_room && {1'b0, code} != nf_q) begin
					state_d = gld_pkg::ST_IDLE;
				end else begin
					state_d = gld_pkg::ST_WALK;
				end
			end
			gld_pkg::ST_WALK: begin
				if (walk_more) begin
					state_d = gld_pkg::ST_WALK_WAIT;
				end else begin
					state_d = unknown_q ? gld_pkg::ST_FIXUP : gld_pkg::ST_POP;
				end
			end
			gld_pkg::ST_WALK_WAIT: state_d = gld_pkg::ST_WALK;
			gld_pkg::ST_FIXUP:     state_d = gld_pkg::ST_POP;
			gld_pkg::ST_POP:       state_d = gld_pkg::ST_POP_WAIT;
			gld_pkg::ST_POP_WAIT:  state_d = gld_pkg::ST_IDLE;
			default:               state_d = gld_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		push_en     = 1'b0;
		push_data   = 8'd0;
		stack_we    = 1'b0;
		stack_waddr = stack_cnt_q[gld_pkg::STACK_AW-1:0];
		stack_wdata = 8'd0;
		stack_raddr = stack_cnt_q[gld_pkg::STACK_AW-1:0] - (gld_pkg::STACK_AW)'(1);
		tab_we      = 1'b0;
		tab_raddr   = walk_q[TAW-1:0];
		emit        = 1'b0;
		res         = '0;
		res.stream_done = done_q;
		res.error_code  = err_q;
		unique case (state_q)
			gld_pkg::ST_IDLE: begin
				emit = take && head.item.func == gld_pkg::FUNC_FEED;
			end
			gld_pkg::ST_DECODE: begin
				if (done_q || err_q != gld_pkg::ERR_OK) begin
					emit = 1'b1;
				end else if (bit_cnt_q < 5'(width_q)) begin
					emit = 1'b1;
					res.need_byte = 1'b1;
				end else if (code == 12'(clr_val)) begin
					emit = 1'b0;
				end else if (code == 12'(clr_val) + 12'd1) begin
					emit = 1'b1;
					res.stream_done = 1'b1;
				end else if (expect_first_q) begin
					if (code >= 12'(color_count_q) || code >= 12'(clr_val)) begin
						emit = 1'b1;
						res.error_code = gld_pkg::ERR_FIRST;
					end else begin
						push_en   = 1'b1;
						push_data = code[7:0];
					end
				end else if ({1'b0, code} < nf_q) begin
					emit = 1'b0;
				end else if (nf_room && {1'b0, code} != nf_q) begin
					emit = 1'b1;
					res.error_code = gld_pkg::ERR_SEQ;
				end else begin
					push_en = 1'b1;
				end
			end
			gld_pkg::ST_WALK: begin
				if (!walk_more) begin
					push_en   = 1'b1;
					push_data = walk_q[7:0];
					tab_we    = nf_room;
				end
			end
			gld_pkg::ST_WALK_WAIT: begin
				push_en   = 1'b1;
				push_data = suffix_rdata;
			end
			gld_pkg::ST_FIXUP: begin
				stack_we    = 1'b1;
				stack_waddr = '0;
				stack_wdata = first_q;
			end
			gld_pkg::ST_POP: begin
				emit = 1'b0;
			end
			gld_pkg::ST_POP_WAIT: begin
				emit = 1'b1;
				res.color_index = stack_rdata;
				res.index_valid = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		if (push_en && stack_cnt_q < SD) begin
			stack_we    = 1'b1;
			stack_wdata = push_data;
		end
	end

	gld_ram #(.WIDTH(8), .DEPTH(gld_pkg::STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stack_we),
		.waddr (stack_waddr),
		.wdata (stack_wdata),
		.raddr (stack_raddr),
		.rdata (stack_rdata)
	);

	gld_ram #(.WIDTH(gld_pkg::CODE_W), .DEPTH(TABLE_DEPTH)) u_prefix (
		.clk   (clk),
		.we    (tab_we),
		.waddr (nf_q[TAW-1:0]),
		.wdata (prev_q),
		.raddr (tab_raddr),
		.rdata (prefix_rdata)
	);

	gld_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_suffix (
		.clk   (clk),
		.we    (tab_we),
		.waddr (nf_q[TAW-1:0]),
		.wdata (walk_q[7:0]),
		.raddr (tab_raddr),
		.rdata (suffix_rdata)
	);

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
		case (state_q)
			gld_pkg::ST_DECODE: begin
				code_q    <= code;
				walk_q    <= ({1'b0, code} < nf_q) ? code : prev_q;
				unknown_q <= !({1'b0, code} < nf_q);
				guard_q   <= '0;
			end
			gld_pkg::ST_WALK: begin
				first_q <= walk_q[7:0];
			end
			gld_pkg::ST_WALK_WAIT: begin
				walk_q  <= prefix_rdata;
				guard_q <= guard_q + 13'd1;
			end
			default: begin
				first_q <= first_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= gld_pkg::ST_IDLE;
			min_q          <= gld_pkg::MIN_SIZE_RST;
			color_count_q  <= gld_pkg::COLOR_COUNT_RST;
			stack_cnt_q    <= '0;
			buf_q          <= '0;
			bit_cnt_q      <= '0;
			width_q        <= gld_pkg::MIN_SIZE_RST + 4'd1;
			nf_q           <= 13'(gld_pkg::COLOR_COUNT_RST) + 13'd2;
			prev_q         <= '0;
			expect_first_q <= 1'b1;
			done_q         <= 1'b0;
			err_q          <= gld_pkg::ERR_OK;
			out_valid_q    <= 1'b0;
		end else if (cfg_we) begin
			state_q        <= gld_pkg::ST_IDLE;
			min_q          <= min_n;
			if (cfg_index == gld_pkg::CFG_COLOR_COUNT) begin
				color_count_q <= cfg_data;
			end
			stack_cnt_q    <= '0;
			buf_q          <= '0;
			bit_cnt_q      <= '0;
			width_q        <= eff_min_n + 4'd1;
			nf_q           <= 13'(clear_n) + 13'd2;
			prev_q         <= '0;
			expect_first_q <= 1'b1;
			done_q         <= 1'b0;
			err_q          <= gld_pkg::ERR_OK;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (push_en && stack_cnt_q < SD) begin
				stack_cnt_q <= stack_cnt_q + 13'd1;
			end
			case (state_q)
				gld_pkg::ST_IDLE: begin
					if (take && head.item.func == gld_pkg::FUNC_FEED
						&& bit_cnt_q <= 5'(gld_pkg::BUF_BITS - 8)) begin
						buf_q     <= buf_q | (24'(head.item.data_byte) << bit_cnt_q);
						bit_cnt_q <= bit_cnt_q + 5'd8;
					end
					if (take && head.item.func == gld_pkg::FUNC_PULL && stack_cnt_q != '0) begin
						stack_cnt_q <= stack_cnt_q - 13'd1;
					end
				end
				gld_pkg::ST_DECODE: begin
					if (!done_q && err_q == gld_pkg::ERR_OK && bit_cnt_q >= 5'(width_q)) begin
						buf_q     <= buf_q >> width_q;
						bit_cnt_q <= bit_cnt_q - 5'(width_q);
						if (code == 12'(clr_val)) begin
							width_q        <= eff_min + 4'd1;
							nf_q           <= 13'(clr_val) + 13'd2;
							expect_first_q <= 1'b1;
						end else if (code == 12'(clr_val) + 12'd1) begin
							done_q <= 1'b1;
						end else if (expect_first_q) begin
							if (code >= 12'(color_count_q) || code >= 12'(clr_val)) begin
								err_q <= gld_pkg::ERR_FIRST;
							end else begin
								prev_q         <= code;
								expect_first_q <= 1'b0;
							end
						end else if (!({1'b0, code} < nf_q)
							&& nf_room && {1'b0, code} != nf_q) begin
							err_q <= gld_pkg::ERR_SEQ;
						end
					end
				end
				gld_pkg::ST_WALK: begin
					if (!walk_more) begin
						nf_q <= nf_inc;
						if (!unknown_q || nf_room) begin
							prev_q <= code_q;
						end
						if (grow) begin
							width_q <= width_q + 4'd1;
						end
					end
				end
				gld_pkg::ST_POP: begin
					stack_cnt_q <= stack_cnt_q - 13'd1;
				end
				default: begin
					err_q <= err_q;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTHESIS
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n) stack_cnt_q <= SD)
		else $error("stack count above depth");
	a_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gld_pkg::ST_WALK_WAIT) |-> ($past(state_q) == gld_pkg::ST_WALK))
		else $error("table data used without a read");
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result overwrote a pending item");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gld_pkg::ST_POP) |-> (stack_cnt_q != '0))
		else $error("pop from empty stack");
`endif

endmodule

// ===== rtl/core/gif_lzw_index_decoder_unit.sv =====
`timescale 1ns / 1ps
// Path from acceptance to result: a feed result is registered straight out; a pull that
// pops the stack goes to POP_WAIT; a first code goes DECODE, POP, POP_WAIT; a table code
// DECODE, then WALK and WALK_WAIT per entry walked, FIXUP if not yet known, POP, POP_WAIT;
// each clear code adds a DECODE pass; need/end/error exits DECODE. One item at a time in
// the decoder; the prefix/suffix table walk (one read port, registered) sets the pace.
// Reset: asynchronous, active low; tables and stack not cleared; config write restarts.
module gif_lzw_index_decoder_unit #(
	parameter int TABLE_DEPTH   = gld_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  gld_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output gld_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [8:0]         cfg_data
);

	gld_pkg::queue_head_t head;
	logic                 pop;

	gld_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.head     (head),
		.pop      (pop)
	);

	gld_core #(
		.TABLE_DEPTH   (TABLE_DEPTH),
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
